[hw/rtl/quaternion_multiply_rotate_top_macros.svh]
// assertion macros for the quaternion multiply and rotate block
// expects clk and rst_n in the scope of each use
`ifndef QUATERNION_MULTIPLY_ROTATE_TOP_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define QMR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qmr assertion failed");

// next-cycle implication, disabled during reset
`define QMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qmr assertion failed");

`endif

[hw/rtl/qmr_pkg.sv]
// shared constants, sign table and sign functions for the quaternion multiply and rotate block
// no dependencies
`default_nettype none

package qmr_pkg;

    localparam int NUM_COMP = 4;
    localparam int NUM_STG  = 6;

    // hamilton product r[k] = sum over m of +/- p[m] * q[k ^ m]; bit m set means subtract
    localparam logic [3:0] NEG_TAB [NUM_COMP] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    function automatic logic mult_neg(input logic [1:0] k, input logic [1:0] m);
        return NEG_TAB[k][m];
    endfunction

    // second product against the conjugate: vector parts of the conjugate flip the sign
    function automatic logic rot_neg(input logic [1:0] k, input logic [1:0] m);
        return NEG_TAB[k][m] ^ (k != m);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/qmr_op_if.sv]
// operand channel: op code and quaternions a and b, valid/ready handshake
// no dependencies
`default_nettype none

interface qmr_op_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [DATA_WIDTH-1:0] a_w;
    logic signed [DATA_WIDTH-1:0] a_x;
    logic signed [DATA_WIDTH-1:0] a_y;
    logic signed [DATA_WIDTH-1:0] a_z;
    logic signed [DATA_WIDTH-1:0] b_w;
    logic signed [DATA_WIDTH-1:0] b_x;
    logic signed [DATA_WIDTH-1:0] b_y;
    logic signed [DATA_WIDTH-1:0] b_z;

    modport source (output valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    input ready);
    modport sink (input valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/qmr_res_if.sv]
// result channel: quaternion or rotated vector plus overflow flag
// no dependencies
`default_nettype none

interface qmr_res_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] r_w;
    logic signed [DATA_WIDTH-1:0] r_x;
    logic signed [DATA_WIDTH-1:0] r_y;
    logic signed [DATA_WIDTH-1:0] r_z;
    logic                         overflow;

    modport source (output valid, r_w, r_x, r_y, r_z, overflow, input ready);
    modport sink (input valid, r_w, r_x, r_y, r_z, overflow, output ready);
endinterface

`default_nettype wire

[hw/rtl/qmr_round_sat.sv]
// round half up by a fixed shift, then saturate to the output width
// no dependencies
`default_nettype none

module qmr_round_sat #(
    parameter int IW    = 34,
    parameter int OW    = 16,
    parameter int SHIFT = 14
) (
    input  logic signed [IW-1:0] value,
    output logic signed [OW-1:0] rounded,
    output logic                 sat
);

    localparam int VW = (IW + 1 > SHIFT + 2) ? IW + 1 : SHIFT + 2;
    localparam logic [VW-1:0] HALF = VW'(1) << (SHIFT - 1);
    localparam logic signed [OW-1:0] MAXV = {1'b0, {(OW - 1){1'b1}}};
    localparam logic signed [OW-1:0] MINV = {1'b1, {(OW - 1){1'b0}}};

    logic signed [VW-1:0] ext;
    logic signed [VW-1:0] biased;
    logic signed [VW-1:0] shifted;
    logic                 in_range;

    always_comb
    begin
        ext      = {{(VW - IW){value[IW-1]}}, value};
        biased   = ext + $signed(HALF);
        shifted  = biased >>> SHIFT;
        in_range = (&shifted[VW-1:OW-1]) || !(|shifted[VW-1:OW-1]);
        sat      = !in_range;
        if (in_range)
        begin
            rounded = shifted[OW-1:0];
        end
        else if (shifted[VW-1])
        begin
            rounded = MINV;
        end
        else
        begin
            rounded = MAXV;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/quaternion_multiply_rotate_top.sv]
// top level of the quaternion multiply and rotate pipeline
// depends on qmr_pkg, qmr_op_if, qmr_res_if, qmr_round_sat and the macro header
//
// usage:
//   operands channel carries op, quaternion a and quaternion b; results channel
//   carries r_w..r_z and overflow. a transaction happens when valid and ready are high.
//   op 0 returns the hamilton product a*b, op 1 rotates (b_x, b_y, b_z) by a as
//   a*v*conj(a) with r_w fixed at zero. components round half up and saturate.
//   the operands land in the first of six register stages at the transaction edge:
//   products, first sums, split partial products for the second product,
//   recombination, second sums, rounding into the output register.
//   throughput is one transaction per cycle while results.ready stays high.
//   reset clears every stage valid bit; no result is presented afterwards until
//   operands arrive.
//   when the receiver stalls, the output register holds its result and empty stages
//   keep filling; operands.ready drops only once all six stages hold data.
`default_nettype none
`include "quaternion_multiply_rotate_top_macros.svh"

module quaternion_multiply_rotate_top
    import qmr_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    qmr_op_if.sink     operands,
    qmr_res_if.source  results
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int TW  = 2 * DW + 2;
    localparam int HW  = DW + 2;
    localparam int HPW = HW + DW;
    localparam int LPW = 2 * DW + 1;
    localparam int UW  = 3 * DW + 2;
    localparam int RW  = 3 * DW + 4;
    localparam int NV  = NUM_COMP - 1;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW - 1){1'b0}}};

    // handshake
    logic [NUM_STG-1:0] load;
    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG-1:0] vld_next;

    // stage 1
    logic signed [DW-1:0] a_in [NUM_COMP];
    logic signed [DW-1:0] b_in [NUM_COMP];
    logic                 op_s1_reg;
    logic signed [DW-1:0] a_s1_reg [NUM_COMP];
    logic signed [PW-1:0] prod_s1_reg [NUM_COMP][NUM_COMP];
    logic signed [PW-1:0] prod_s1_next [NUM_COMP][NUM_COMP];

    // stage 2
    logic                 op_s2_reg;
    logic signed [DW-1:0] a_s2_reg [NUM_COMP];
    logic signed [TW-1:0] t_s2_reg [NUM_COMP];
    logic signed [TW-1:0] t_s2_next [NUM_COMP];

    // stage 3
    logic                  op_s3_reg;
    logic signed [TW-1:0]  t_s3_reg [NUM_COMP];
    logic signed [HPW-1:0] hp_s3_reg [NV][NUM_COMP];
    logic signed [HPW-1:0] hp_s3_next [NV][NUM_COMP];
    logic signed [LPW-1:0] lp_s3_reg [NV][NUM_COMP];
    logic signed [LPW-1:0] lp_s3_next [NV][NUM_COMP];

    // stage 4
    logic                 op_s4_reg;
    logic signed [TW-1:0] t_s4_reg [NUM_COMP];
    logic signed [UW-1:0] u_s4_reg [NV][NUM_COMP];
    logic signed [UW-1:0] u_s4_next [NV][NUM_COMP];

    // stage 5
    logic                 op_s5_reg;
    logic signed [TW-1:0] t_s5_reg [NUM_COMP];
    logic signed [RW-1:0] r_s5_reg [NV];
    logic signed [RW-1:0] r_s5_next [NV];

    // stage 6
    logic signed [DW-1:0] mult_res [NUM_COMP];
    logic [NUM_COMP-1:0]  mult_sat;
    logic signed [DW-1:0] rot_res [NV];
    logic [NV-1:0]        rot_sat;
    logic                 op_s6_reg;
    logic signed [DW-1:0] r_s6_reg [NUM_COMP];
    logic signed [DW-1:0] r_s6_next [NUM_COMP];
    logic                 ovf_s6_reg;
    logic                 ovf_s6_next;

    // stage enables, bubbles collapse
    always_comb
    begin
        load[NUM_STG-1] = !vld_reg[NUM_STG-1] || results.ready;
        for (int k = NUM_STG - 2; k >= 0; k--)
        begin
            load[k] = !vld_reg[k] || load[k+1];
        end
        vld_next[0] = load[0] ? operands.valid : vld_reg[0];
        for (int k = 1; k < NUM_STG; k++)
        begin
            vld_next[k] = load[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign operands.ready = load[0];

    // stage 1: all sixteen products
    always_comb
    begin
        a_in[0] = operands.a_w;
        a_in[1] = operands.a_x;
        a_in[2] = operands.a_y;
        a_in[3] = operands.a_z;
        b_in[0] = operands.op ? '0 : operands.b_w;
        b_in[1] = operands.b_x;
        b_in[2] = operands.b_y;
        b_in[3] = operands.b_z;
        for (int k = 0; k < NUM_COMP; k++)
        begin
            for (int m = 0; m < NUM_COMP; m++)
            begin
                prod_s1_next[k][m] = a_in[m] * b_in[2'(k ^ m)];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            op_s1_reg   <= operands.op;
            a_s1_reg    <= a_in;
            prod_s1_reg <= prod_s1_next;
        end
    end

    // stage 2: first hamilton sums
    always_comb
    begin
        logic signed [TW-1:0] term;
        logic signed [TW-1:0] acc;
        for (int k = 0; k < NUM_COMP; k++)
        begin
            acc = '0;
            for (int m = 0; m < NUM_COMP; m++)
            begin
                term = {{(TW - PW){prod_s1_reg[k][m][PW-1]}}, prod_s1_reg[k][m]};
                if (mult_neg(2'(k), 2'(m)))
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            t_s2_next[k] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            op_s2_reg <= op_s1_reg;
            a_s2_reg  <= a_s1_reg;
            t_s2_reg  <= t_s2_next;
        end
    end

    // stage 3: t times a, split into high and low partial products
    always_comb
    begin
        logic signed [HW-1:0] hi;
        logic signed [DW:0]   lo;
        for (int k = 1; k < NUM_COMP; k++)
        begin
            for (int m = 0; m < NUM_COMP; m++)
            begin
                hi = t_s2_reg[m][TW-1:DW];
                lo = {1'b0, t_s2_reg[m][DW-1:0]};
                hp_s3_next[k-1][m] = hi * a_s2_reg[2'(k ^ m)];
                lp_s3_next[k-1][m] = lo * a_s2_reg[2'(k ^ m)];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            op_s3_reg <= op_s2_reg;
            t_s3_reg  <= t_s2_reg;
            hp_s3_reg <= hp_s3_next;
            lp_s3_reg <= lp_s3_next;
        end
    end

    // stage 4: recombine partial products
    always_comb
    begin
        for (int k = 0; k < NV; k++)
        begin
            for (int m = 0; m < NUM_COMP; m++)
            begin
                u_s4_next[k][m] = {hp_s3_reg[k][m], {DW{1'b0}}}
                                + {{(UW - LPW){lp_s3_reg[k][m][LPW-1]}}, lp_s3_reg[k][m]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            op_s4_reg <= op_s3_reg;
            t_s4_reg  <= t_s3_reg;
            u_s4_reg  <= u_s4_next;
        end
    end

    // stage 5: sums against the conjugate
    always_comb
    begin
        logic signed [RW-1:0] term;
        logic signed [RW-1:0] acc;
        for (int k = 1; k < NUM_COMP; k++)
        begin
            acc = '0;
            for (int m = 0; m < NUM_COMP; m++)
            begin
                term = {{(RW - UW){u_s4_reg[k-1][m][UW-1]}}, u_s4_reg[k-1][m]};
                if (rot_neg(2'(k), 2'(m)))
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            r_s5_next[k-1] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            op_s5_reg <= op_s4_reg;
            t_s5_reg  <= t_s4_reg;
            r_s5_reg  <= r_s5_next;
        end
    end

    // stage 6: round, saturate, select
    genvar g;
    generate
        for (g = 0; g < NUM_COMP; g++)
        begin : g_mult
            qmr_round_sat #(
                .IW    (TW),
                .OW    (DW),
                .SHIFT (FRAC_BITS)
            ) u_mult_rs (
                .value   (t_s5_reg[g]),
                .rounded (mult_res[g]),
                .sat     (mult_sat[g])
            );
        end
        for (g = 0; g < NV; g++)
        begin : g_rot
            qmr_round_sat #(
                .IW    (RW),
                .OW    (DW),
                .SHIFT (2 * FRAC_BITS)
            ) u_rot_rs (
                .value   (r_s5_reg[g]),
                .rounded (rot_res[g]),
                .sat     (rot_sat[g])
            );
        end
    endgenerate

    always_comb
    begin
        if (op_s5_reg)
        begin
            r_s6_next[0] = '0;
            for (int k = 1; k < NUM_COMP; k++)
            begin
                r_s6_next[k] = rot_res[k-1];
            end
            ovf_s6_next = |rot_sat;
        end
        else
        begin
            r_s6_next   = mult_res;
            ovf_s6_next = |mult_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            op_s6_reg  <= op_s5_reg;
            r_s6_reg   <= r_s6_next;
            ovf_s6_reg <= ovf_s6_next;
        end
    end

    assign results.valid    = vld_reg[NUM_STG-1];
    assign results.r_w      = r_s6_reg[0];
    assign results.r_x      = r_s6_reg[1];
    assign results.r_y      = r_s6_reg[2];
    assign results.r_z      = r_s6_reg[3];
    assign results.overflow = ovf_s6_reg;

    `QMR_ASSERT_NEXT(a_accept_fills_first, operands.valid && operands.ready, vld_reg[0])
    `QMR_ASSERT_IMPL(a_empty_out_ready, !results.valid, operands.ready)
    `QMR_ASSERT_IMPL(a_rot_w_zero, results.valid && op_s6_reg, results.r_w == '0)
    `QMR_ASSERT_IMPL(a_ovf_at_bound, results.valid && results.overflow,
        results.r_w == MAXV || results.r_w == MINV || results.r_x == MAXV ||
        results.r_x == MINV || results.r_y == MAXV || results.r_y == MINV ||
        results.r_z == MAXV || results.r_z == MINV)

endmodule

`default_nettype wire

[dv/tb.sv]
// self-checking testbench for quaternion_multiply_rotate_top: hamilton products and vector rotations
// depends on qmr_pkg, qmr_op_if, qmr_res_if and the quaternion_multiply_rotate_top rtl
`default_nettype none

module tb
    import qmr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTS = 40;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_ROT = 1'b1;

    localparam int MAG_FULL   = 0;
    localparam int MAG_UNIT   = 1;
    localparam int MAG_SMALL  = 2;
    localparam int MAG_CORNER = 3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE,
        RX_PATTERN
    } rx_mode_t;

    typedef struct packed {
        logic          op;
        logic [DW-1:0] a_w;
        logic [DW-1:0] a_x;
        logic [DW-1:0] a_y;
        logic [DW-1:0] a_z;
        logic [DW-1:0] b_w;
        logic [DW-1:0] b_x;
        logic [DW-1:0] b_y;
        logic [DW-1:0] b_z;
    } quat_op_t;

    typedef struct packed {
        logic [DW-1:0] r_w;
        logic [DW-1:0] r_x;
        logic [DW-1:0] r_y;
        logic [DW-1:0] r_z;
        logic          overflow;
    } quat_res_t;

    typedef struct packed {
        longint w;
        longint x;
        longint y;
        longint z;
    } quad_t;

    logic clk;
    logic rst_n;

    qmr_op_if  #(.DATA_WIDTH(DW)) op_ch ();
    qmr_res_if #(.DATA_WIDTH(DW)) res_ch ();

    quaternion_multiply_rotate_top #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operands(op_ch),
        .results (res_ch)
    );

    quat_op_t  pending_q[$];
    quat_res_t expected_q[$];

    quat_op_t    cur_op;
    logic        drv_busy;
    int unsigned burst_left;
    int unsigned gap_left;

    rx_mode_t    rx_mode;
    int unsigned rx_left;
    logic [10:0] rx_pat;
    logic        rx_rdy;

    int unsigned err_count;
    int unsigned n_results;
    int unsigned n_mul;
    int unsigned n_rot;
    int unsigned n_sat;
    int unsigned idle_cycles;

    function automatic quad_t hamilton_exact(quad_t p, quad_t q);
        quad_t r;
        r.w = p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z;
        r.x = p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y;
        r.y = p.w * q.y - p.x * q.z + p.y * q.w + p.z * q.x;
        r.z = p.w * q.z + p.x * q.y - p.y * q.x + p.z * q.w;
        return r;
    endfunction

    // {saturated, value}: round half up, then clamp to the signed range
    function automatic logic [DW:0] round_clamp(longint v, int sh);
        longint hi;
        longint lo;
        longint t;
        hi = (64'sd1 <<< (DW - 1)) - 1;
        lo = -hi - 1;
        t  = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (t > hi)
            return {1'b1, hi[DW-1:0]};
        if (t < lo)
            return {1'b1, lo[DW-1:0]};
        return {1'b0, t[DW-1:0]};
    endfunction

    function automatic quat_res_t quat_eval(quat_op_t q);
        quad_t       a;
        quad_t       b;
        quad_t       conj;
        quad_t       prod;
        logic [DW:0] cw;
        logic [DW:0] cx;
        logic [DW:0] cy;
        logic [DW:0] cz;
        quat_res_t   res;
        a.w = longint'($signed(q.a_w));
        a.x = longint'($signed(q.a_x));
        a.y = longint'($signed(q.a_y));
        a.z = longint'($signed(q.a_z));
        b.w = (q.op == OP_ROT) ? 64'sd0 : longint'($signed(q.b_w));
        b.x = longint'($signed(q.b_x));
        b.y = longint'($signed(q.b_y));
        b.z = longint'($signed(q.b_z));
        if (q.op == OP_MUL)
        begin
            prod = hamilton_exact(a, b);
            cw = round_clamp(prod.w, FB);
            cx = round_clamp(prod.x, FB);
            cy = round_clamp(prod.y, FB);
            cz = round_clamp(prod.z, FB);
        end
        else
        begin
            conj.w = a.w;
            conj.x = -a.x;
            conj.y = -a.y;
            conj.z = -a.z;
            prod = hamilton_exact(hamilton_exact(a, b), conj);
            cw = '0;
            cx = round_clamp(prod.x, 2 * FB);
            cy = round_clamp(prod.y, 2 * FB);
            cz = round_clamp(prod.z, 2 * FB);
        end
        res.r_w      = cw[DW-1:0];
        res.r_x      = cx[DW-1:0];
        res.r_y      = cy[DW-1:0];
        res.r_z      = cz[DW-1:0];
        res.overflow = cw[DW] | cx[DW] | cy[DW] | cz[DW];
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("error @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic signed [DW:0] got,
                               input logic signed [DW:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0d expected %0d",
                                   n_results, name, got, want));
    endtask

    task automatic add_item(input logic op, input int aw, input int ax, input int ay,
                            input int az, input int bw, input int bx, input int by,
                            input int bz);
        quat_op_t q;
        q.op  = op;
        q.a_w = DW'(aw);
        q.a_x = DW'(ax);
        q.a_y = DW'(ay);
        q.a_z = DW'(az);
        q.b_w = DW'(bw);
        q.b_x = DW'(bx);
        q.b_y = DW'(by);
        q.b_z = DW'(bz);
        pending_q.push_back(q);
    endtask

    function automatic int pick_kind();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return MAG_FULL;
        if (r < 7)
            return MAG_UNIT;
        if (r < 9)
            return MAG_SMALL;
        return MAG_CORNER;
    endfunction

    function automatic int pick_comp(int kind);
        case (kind)
            MAG_FULL:  return int'($urandom_range(0, 65535)) - 32768;
            MAG_UNIT:  return int'($urandom_range(0, 32768)) - 16384;
            MAG_SMALL: return int'($urandom_range(0, 512)) - 256;
            default:
            begin
                case ($urandom_range(0, 8))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return -32767;
                    3:       return -1;
                    4:       return 0;
                    5:       return 1;
                    6:       return 16384;
                    7:       return -16384;
                    default: return 8192;
                endcase
            end
        endcase
    endfunction

    task automatic add_random(input int unsigned count);
        int ka;
        int kb;
        repeat (count)
        begin
            ka = pick_kind();
            kb = pick_kind();
            add_item(1'($urandom_range(0, 1)),
                     pick_comp(ka), pick_comp(ka), pick_comp(ka), pick_comp(ka),
                     pick_comp(kb), pick_comp(kb), pick_comp(kb), pick_comp(kb));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_q.size() != 0 || op_ch.valid || expected_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        op_ch.valid  = 1'b0;
        op_ch.op     = OP_MUL;
        op_ch.a_w    = '0;
        op_ch.a_x    = '0;
        op_ch.a_y    = '0;
        op_ch.a_z    = '0;
        op_ch.b_w    = '0;
        op_ch.b_x    = '0;
        op_ch.b_y    = '0;
        op_ch.b_z    = '0;
        res_ch.ready = 1'b0;
        forever #6 clk = ~clk;
    end

    // operand driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            cur_op     = '0;
        end
        else
        begin
            drv_busy = op_ch.valid;
            if (op_ch.valid && op_ch.ready)
            begin
                expected_q.push_back(quat_eval(cur_op));
                if (cur_op.op == OP_ROT)
                    n_rot++;
                else
                    n_mul++;
                drv_busy = 1'b0;
            end
            if (!drv_busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() != 0)
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    cur_op   = pending_q.pop_front();
                    drv_busy = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                end
            end
            op_ch.valid <= drv_busy;
            op_ch.op    <= cur_op.op;
            op_ch.a_w   <= cur_op.a_w;
            op_ch.a_x   <= cur_op.a_x;
            op_ch.a_y   <= cur_op.a_y;
            op_ch.a_z   <= cur_op.a_z;
            op_ch.b_w   <= cur_op.b_w;
            op_ch.b_x   <= cur_op.b_x;
            op_ch.b_y   <= cur_op.b_y;
            op_ch.b_z   <= cur_op.b_z;
        end
    end

    // result monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        quat_res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            rx_mode = RX_OPEN;
            rx_left = 0;
            rx_pat  = 11'b10110011101;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report_error($sformatf("result %0d arrived with nothing expected", n_results));
                else
                begin
                    want = expected_q.pop_front();
                    check_field("r_w", $signed(res_ch.r_w), $signed(want.r_w));
                    check_field("r_x", $signed(res_ch.r_x), $signed(want.r_x));
                    check_field("r_y", $signed(res_ch.r_y), $signed(want.r_y));
                    check_field("r_z", $signed(res_ch.r_z), $signed(want.r_z));
                    check_field("overflow", res_ch.overflow, want.overflow);
                    if (want.overflow)
                        n_sat++;
                end
                n_results++;
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 80);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:  rx_rdy = 1'b1;
                RX_COIN:  rx_rdy = 1'($urandom_range(0, 1));
                RX_CHOKE: rx_rdy = ($urandom_range(0, 3) == 0);
                default:
                begin
                    rx_rdy = rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[10:1]};
                end
            endcase
            res_ch.ready <= rx_rdy;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_q.size());
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        err_count = 0;
        n_results = 0;
        n_mul     = 0;
        n_rot     = 0;
        n_sat     = 0;

        // multiplies: identities, unit axes, extremes, rounding halves
        add_item(OP_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0);
        add_item(OP_MUL, 0, 16384, 0, 0, 0, 0, 16384, 0);
        add_item(OP_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_item(OP_MUL, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_item(OP_MUL, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
        add_item(OP_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(OP_MUL, 1, 0, 0, 0, 8192, 8192, -8192, -8191);
        add_item(OP_MUL, -1, 0, 0, 0, 8192, -8192, 8193, 0);
        add_item(OP_MUL, 32767, 0, 0, 0, 32767, 0, 0, 0);
        add_item(OP_MUL, 'h5555, 'haaaa, 'h5555, 'haaaa, 'haaaa, 'h5555, 'haaaa, 'h5555);
        // rotations: identity, quarter and half turns, ignored scalar, non-unit growth
        add_item(OP_ROT, 16384, 0, 0, 0, 0, 1234, -5678, 9012);
        add_item(OP_ROT, 11585, 0, 0, 11585, 32767, 16384, 0, 0);
        add_item(OP_ROT, 0, 16384, 0, 0, -32768, 1000, -2000, 3000);
        add_item(OP_ROT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_item(OP_ROT, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_item(OP_ROT, 0, 0, 0, 0, 12345, 32767, -32768, 100);
        add_item(OP_ROT, 11585, 11585, 0, 0, -1, 0, 0, 0);
        add_item(OP_ROT, 'h5555, 'haaaa, 'h5555, 'haaaa, 'haaaa, 'h5555, 'haaaa, 'h5555);
        add_item(OP_ROT, 1, 1, 1, 1, 0, 32767, -32768, 32767);
        add_item(OP_ROT, 8192, 8192, 8192, 8192, 0, 16384, -16384, 8192);
        add_item(OP_ROT, -16384, 0, 0, 0, 7, -32768, 32767, -8192);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        add_random(950);
        wait_drained();
        add_random(950);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (expected_q.size() != 0)
            report_error($sformatf("%0d expected results never arrived", expected_q.size()));

        $display("summary: %0d multiplies and %0d rotations sent, %0d results checked",
                 n_mul, n_rot, n_results);
        $display("summary: %0d results saturated, %0d mismatches", n_sat, err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/qmr_pkg.sv
hw/rtl/qmr_op_if.sv
hw/rtl/qmr_res_if.sv
hw/rtl/qmr_round_sat.sv
hw/rtl/quaternion_multiply_rotate_top.sv
dv/tb.sv
